FILE: rtl/core/golpf_pkg.sv
// Shared types, constants and the byte classifier for the GRE/OSPF LSA packet filter.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package golpf_pkg;

    localparam int MAX_LINKS_SCANNED = 10;
    localparam int LINKS_START       = 110;
    localparam int LINK_SIZE         = 12;
    localparam int LINK_FIRST_END    = LINKS_START + LINK_SIZE - 1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_GRE      = 8'd47;
    localparam logic [7:0]  PROTO_OSPF     = 8'd89;
    localparam logic [7:0]  OSPF_TYPE_DD   = 8'd2;
    localparam logic [7:0]  OSPF_TYPE_LSU  = 8'd4;
    localparam logic [7:0]  LSA_ROUTER     = 8'd1;
    localparam logic [7:0]  LINK_P2P       = 8'd1;
    localparam logic [7:0]  LINK_BROADCAST = 8'd2;
    localparam logic [15:0] DD_EMPTY_LEN   = 16'd32;
    localparam logic [15:0] DD_ONE_LSA_LEN = 16'd52;

    localparam logic [7:0] POS_MAX        = 8'd255;
    localparam logic [7:0] POS_MIN_FRAME  = 8'd13;
    localparam logic [7:0] POS_LINK_COUNT = 8'd109;

    // Result reason codes.
    localparam logic [3:0] REASON_PASS         = 4'd0;
    localparam logic [3:0] REASON_SHORT        = 4'd1;
    localparam logic [3:0] REASON_DD_NONROUTER = 4'd2;
    localparam logic [3:0] REASON_DD_EXTRA     = 4'd3;
    localparam logic [3:0] REASON_LSA_COUNT    = 4'd4;
    localparam logic [3:0] REASON_LSU_NONROUTER = 4'd5;
    localparam logic [3:0] REASON_LINKS        = 4'd6;
    localparam logic [3:0] REASON_BROADCAST    = 4'd7;
    localparam logic [3:0] REASON_NO_P2P       = 4'd8;

    // Configuration register map.
    localparam int          PADDR_W       = 3;
    localparam logic [0:0]  REG_LSA_COUNT = 1'b0;
    localparam logic [0:0]  REG_MAX_LINKS = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Byte positions at which the back end has something to check.
    typedef enum logic [3:0] {
        PT_NONE,
        PT_ETYPE_OUTER,
        PT_PROTO_GRE,
        PT_ETYPE_INNER,
        PT_PROTO_OSPF,
        PT_OSPF_TYPE,
        PT_OSPF_LEN,
        PT_LSU_COUNT,
        PT_LSU_LSA_TYPE,
        PT_DD_LSA_TYPE,
        PT_LSU_HDR_END,
        PT_LINK_COUNT,
        PT_LINK_END
    } point_t;

    typedef struct packed {
        point_t      point;
        logic [7:0]  data;
        logic [31:0] shifter;
        logic        last;
        logic        short_frame;
        logic        past_link_count;
    } item_t;

    typedef struct packed {
        logic [31:0] allowed_lsa_count;
        logic [15:0] max_router_links;
    } cfg_t;

    function automatic point_t classify(input logic [7:0] pos);
        point_t pt;
        pt = PT_NONE;
        for (int i = 0; i < MAX_LINKS_SCANNED; i++) begin
            if (pos == 8'(LINK_FIRST_END + i * LINK_SIZE))
                pt = PT_LINK_END;
        end
        unique case (pos)
            8'd13:   pt = PT_ETYPE_OUTER;
            8'd23:   pt = PT_PROTO_GRE;
            8'd37:   pt = PT_ETYPE_INNER;
            8'd47:   pt = PT_PROTO_OSPF;
            8'd59:   pt = PT_OSPF_TYPE;
            8'd61:   pt = PT_OSPF_LEN;
            8'd85:   pt = PT_LSU_COUNT;
            8'd89:   pt = PT_LSU_LSA_TYPE;
            8'd93:   pt = PT_DD_LSA_TYPE;
            8'd105:  pt = PT_LSU_HDR_END;
            8'd109:  pt = PT_LINK_COUNT;
            default: pt = pt;
        endcase
        return pt;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/golpf_front.sv
// Front end: accepts frame bytes, tracks byte position and the last four bytes,
// and tags each byte with the check it triggers. Depends on golpf_pkg.
`default_nettype none

module golpf_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [7:0]     frame_byte,
    input  wire logic           end_of_frame,
    input  wire logic           queue_full,
    output logic                push,
    output golpf_pkg::item_t    push_item
);
    import golpf_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [31:0] shifter_reg, shifter_next;
    logic [31:0] shifted;

    assign push    = in_valid && !queue_full;
    assign shifted = {shifter_reg[23:0], frame_byte};

    always_comb
    begin
        pos_next     = pos_reg;
        shifter_next = shifter_reg;
        if (push)
        begin
            if (end_of_frame)
            begin
                pos_next     = '0;
                shifter_next = '0;
            end
            else
            begin
                pos_next     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
                shifter_next = shifted;
            end
        end
    end

    always_comb
    begin
        push_item.point           = classify(pos_reg);
        push_item.data            = frame_byte;
        push_item.shifter         = shifted;
        push_item.last            = end_of_frame;
        push_item.short_frame     = pos_reg < POS_MIN_FRAME;
        push_item.past_link_count = pos_reg >= POS_LINK_COUNT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            shifter_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            shifter_reg <= shifter_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/golpf_queue.sv
// Short FIFO of tagged bytes between the front and back ends.
// Depends on golpf_pkg for the item type and depth.
`default_nettype none

module golpf_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire golpf_pkg::item_t  push_item,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output golpf_pkg::item_t       head
);
    import golpf_pkg::*;

    item_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/golpf_back.sv
// Back end: runs the header and LSA checks on tagged bytes, forms the verdict
// at frame end and holds it in the output register. Depends on golpf_pkg.
`default_nettype none

module golpf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire golpf_pkg::cfg_t   cfg,
    input  wire logic              item_valid,
    input  wire golpf_pkg::item_t  item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   drop,
    output logic [3:0]             reason
);
    import golpf_pkg::*;

    logic        match_reg, match_next;
    logic        lsu_reg, lsu_next;
    logic [15:0] ospf_len_reg, ospf_len_next;
    logic        decided_reg, decided_next;
    logic [3:0]  held_reg, held_next;
    logic        p2p_reg, p2p_next;
    logic        out_valid_reg, out_valid_next;
    logic        drop_reg;
    logic [3:0]  reason_reg;
    logic [3:0]  why;
    logic        load_out;

    // A final byte waits here while the previous verdict is still stalled.
    assign pop      = item_valid && (!item.last || !out_valid_reg || !out_stall);
    assign load_out = pop && item.last;

    always_comb
    begin
        match_next    = match_reg;
        lsu_next      = lsu_reg;
        ospf_len_next = ospf_len_reg;
        decided_next  = decided_reg;
        held_next     = held_reg;
        p2p_next      = p2p_reg;
        if (pop && match_reg && !decided_reg)
        begin
            unique case (item.point)
                PT_ETYPE_OUTER, PT_ETYPE_INNER:
                    if (item.shifter[15:0] != ETHERTYPE_IPV4)
                        match_next = 1'b0;
                PT_PROTO_GRE:
                    if (item.data != PROTO_GRE)
                        match_next = 1'b0;
                PT_PROTO_OSPF:
                    if (item.data != PROTO_OSPF)
                        match_next = 1'b0;
                PT_OSPF_TYPE:
                    if (item.data == OSPF_TYPE_LSU)
                        lsu_next = 1'b1;
                    else if (item.data != OSPF_TYPE_DD)
                        match_next = 1'b0;
                PT_OSPF_LEN:
                    ospf_len_next = item.shifter[15:0];
                PT_DD_LSA_TYPE:
                    if (!lsu_reg)
                    begin
                        if (ospf_len_reg == DD_EMPTY_LEN)
                            held_next = REASON_PASS;
                        else if (item.data != LSA_ROUTER)
                            held_next = REASON_DD_NONROUTER;
                        else if (ospf_len_reg != DD_ONE_LSA_LEN)
                            held_next = REASON_DD_EXTRA;
                        else
                            held_next = REASON_PASS;
                    end
                PT_LSU_COUNT:
                    if (lsu_reg && item.shifter != cfg.allowed_lsa_count)
                    begin
                        decided_next = 1'b1;
                        held_next    = REASON_LSA_COUNT;
                    end
                PT_LSU_LSA_TYPE:
                    if (lsu_reg)
                        held_next = (item.data != LSA_ROUTER) ? REASON_LSU_NONROUTER
                                                              : REASON_PASS;
                PT_LSU_HDR_END:
                    if (lsu_reg && held_reg != REASON_PASS)
                        decided_next = 1'b1;
                PT_LINK_COUNT:
                    if (!lsu_reg)
                    begin
                        // A DD packet with nothing wrong stops being examined here.
                        if (held_reg != REASON_PASS)
                            decided_next = 1'b1;
                        else
                            match_next = 1'b0;
                    end
                    else if (item.shifter[15:0] > cfg.max_router_links)
                    begin
                        decided_next = 1'b1;
                        held_next    = REASON_LINKS;
                    end
                PT_LINK_END:
                    if (lsu_reg)
                    begin
                        if (item.shifter[31:24] == LINK_P2P)
                            p2p_next = 1'b1;
                        else if (item.shifter[31:24] == LINK_BROADCAST)
                        begin
                            decided_next = 1'b1;
                            held_next    = REASON_BROADCAST;
                        end
                    end
                PT_NONE: ;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (decided_next)
            why = held_next;
        else if (item.short_frame)
            why = REASON_SHORT;
        else if (match_next && lsu_next && item.past_link_count && !p2p_next)
            why = REASON_NO_P2P;
        else
            why = REASON_PASS;
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= 1'b1;
            lsu_reg       <= 1'b0;
            ospf_len_reg  <= '0;
            decided_reg   <= 1'b0;
            held_reg      <= REASON_PASS;
            p2p_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                match_reg    <= 1'b1;
                lsu_reg      <= 1'b0;
                ospf_len_reg <= '0;
                decided_reg  <= 1'b0;
                held_reg     <= REASON_PASS;
                p2p_reg      <= 1'b0;
            end
            else
            begin
                match_reg    <= match_next;
                lsu_reg      <= lsu_next;
                ospf_len_reg <= ospf_len_next;
                decided_reg  <= decided_next;
                held_reg     <= held_next;
                p2p_reg      <= p2p_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            drop_reg   <= why != REASON_PASS;
            reason_reg <= why;
        end
    end

    assign out_valid = out_valid_reg;
    assign drop      = drop_reg;
    assign reason    = reason_reg;

endmodule

`default_nettype wire

FILE: rtl/core/gre_ospf_lsa_packet_filter.sv
// Top level of the GRE/OSPF LSA packet filter: front end, queue, back end and
// the configuration registers. Depends on golpf_pkg and the golpf_* modules.
//
// The filter takes one frame byte per clock cycle while in_stall is low, and
// gives one drop/reason verdict per frame. out_valid rises once the frame's last
// byte has passed through the queue and the verdict is in the output register,
// so earlier queued bytes or a stalled earlier verdict can hold it back. The front
// end tags each byte with the check its position triggers; a four-entry queue
// carries the tagged bytes to the back end, which runs the checks and loads the
// verdict into the output register. in_stall rises only when that queue is
// full, which happens when verdicts are held back on the output side.
// Registers: allowed_lsa_count at address 0 (reset 1), max_router_links at
// address 4 (reset 2); write them only while no frame is in flight.
`default_nettype none

module gre_ospf_lsa_packet_filter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      frame_byte,
    input  wire logic                            end_of_frame,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 drop,
    output logic [3:0]                           reason,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [golpf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import golpf_pkg::*;

    logic        queue_full, queue_not_empty;
    logic        push, pop;
    item_t       push_item, head_item;
    cfg_t        cfg;
    logic [31:0] allowed_lsa_count_reg;
    logic [15:0] max_router_links_reg;
    logic        cfg_write;
    logic [0:0]  reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allowed_lsa_count_reg <= 32'd1;
            max_router_links_reg  <= 16'd2;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_LSA_COUNT: allowed_lsa_count_reg <= pwdata;
                REG_MAX_LINKS: max_router_links_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_LSA_COUNT: prdata = allowed_lsa_count_reg;
            REG_MAX_LINKS: prdata = {16'd0, max_router_links_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.allowed_lsa_count = allowed_lsa_count_reg;
    assign cfg.max_router_links  = max_router_links_reg;
    assign in_stall              = queue_full;

    golpf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item)
    );

    golpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_item)
    );

    golpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drop       (drop),
        .reason     (reason)
    );

endmodule

`default_nettype wire

FILE: rtl/core/golpf_checker.sv
// Port-level assertions for the GRE/OSPF LSA packet filter, bound to the top level.
// Depends on golpf_pkg for the reason codes.
`default_nettype none

module golpf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       drop,
    input wire logic [3:0] reason,
    input wire logic       pready
);
    import golpf_pkg::*;

    // A verdict drops exactly when it carries a nonzero reason.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drop == (reason != REASON_PASS)))
        else $error("drop disagrees with reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reason <= REASON_NO_P2P))
        else $error("reason code out of range");

    // A stalled verdict stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drop) && $stable(reason))
        else $error("stalled verdict changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind gre_ospf_lsa_packet_filter golpf_checker u_golpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drop      (drop),
    .reason    (reason),
    .pready    (pready)
);

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the GRE/OSPF LSA packet filter: streams frames byte by byte,
// predicts each drop/reason verdict on the fly and scores the filter's output against it.
// Depends on golpf_pkg and the gre_ospf_lsa_packet_filter RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import golpf_pkg::*;

    localparam int CLK_HIGH      = 10;
    localparam int CLK_LOW       = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_LIMIT    = 1000;

    localparam logic [PADDR_W-1:0] ADDR_LSA_COUNT = {REG_LSA_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_MAX_LINKS = {REG_MAX_LINKS, 2'b00};

    // Byte offsets of the fields the filter looks at, counted from the Ethernet destination.
    localparam int POS_ETYPE_OUTER  = 13;
    localparam int POS_PROTO_GRE    = 23;
    localparam int POS_ETYPE_INNER  = 37;
    localparam int POS_PROTO_OSPF   = 47;
    localparam int POS_OSPF_TYPE    = 59;
    localparam int POS_OSPF_LEN     = 61;
    localparam int OSPF_BODY        = 82;
    localparam int POS_LSU_COUNT    = 85;
    localparam int POS_LSU_LSA_TYPE = 89;
    localparam int POS_DD_LSA_TYPE  = 93;
    localparam int POS_LSU_HDR_END  = 105;

    localparam logic [7:0] OSPF_TYPE_HELLO = 8'd1;
    localparam logic [7:0] LINK_STUB       = 8'd3;
    localparam logic [7:0] ETYPE_OTHER_LO  = 8'hDD;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic       drop;
        logic [3:0] reason;
    } verdict_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          frame_byte = 8'h00;
    logic                end_of_frame = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                drop;
    logic [3:0]          reason;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = 32'h0;
    logic [31:0]         prdata;
    logic                pready;

    // Stimulus and expectations.
    beat_t      pending_bytes[$];
    verdict_t   expected_verdicts[$];
    logic [7:0] frame_bytes[$];

    // Predicted filter state and its copy of the registers.
    logic [31:0] cfg_lsa_count = 32'd1;
    logic [15:0] cfg_max_links = 16'd2;
    logic [7:0]  flt_pos;
    logic        flt_matching;
    logic        flt_lsu;
    logic [15:0] flt_ospf_len;
    logic [31:0] flt_window;
    logic        flt_decided;
    logic [3:0]  flt_held;
    logic        flt_p2p;

    int    mismatches = 0;
    int    verdicts_seen = 0;
    int    idle_cycles = 0;
    int    in_wait = 0;
    int    out_wait = 0;
    logic  calm_in = 1'b0;
    logic  calm_out = 1'b0;
    beat_t next_beat;
    verdict_t want;

    gre_ospf_lsa_packet_filter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drop         (drop),
        .reason       (reason),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #CLK_HIGH clk = 1'b0;
        #CLK_LOW clk = 1'b1;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("ERROR at %0t, verdict %0d: %s", $time, verdicts_seen, what);
    endtask

    function automatic int draw_wait(input logic calm);
        if (calm)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, GAP_MAX);
        return $urandom_range(0, 2);
    endfunction

    task automatic clear_frame_state();
        flt_pos      = 8'd0;
        flt_matching = 1'b1;
        flt_lsu      = 1'b0;
        flt_ospf_len = 16'd0;
        flt_window   = 32'd0;
        flt_decided  = 1'b0;
        flt_held     = REASON_PASS;
        flt_p2p      = 1'b0;
    endtask

    task automatic latch_drop(input logic [3:0] why);
        flt_decided = 1'b1;
        flt_held    = why;
    endtask

    // Advances the predicted filter by one accepted byte; the frame's last byte
    // yields the expected verdict.
    task automatic track_byte(input logic [7:0] b, input logic last);
        int unsigned p;
        int unsigned off;
        logic [3:0]  why;
        p = flt_pos;
        why = REASON_PASS;
        flt_window = {flt_window[23:0], b};
        if (flt_matching && !flt_decided) begin
            if (p == POS_ETYPE_OUTER || p == POS_ETYPE_INNER) begin
                if (flt_window[15:0] != ETHERTYPE_IPV4)
                    flt_matching = 1'b0;
            end else if (p == POS_PROTO_GRE) begin
                if (b != PROTO_GRE)
                    flt_matching = 1'b0;
            end else if (p == POS_PROTO_OSPF) begin
                if (b != PROTO_OSPF)
                    flt_matching = 1'b0;
            end else if (p == POS_OSPF_TYPE) begin
                if (b == OSPF_TYPE_LSU)
                    flt_lsu = 1'b1;
                else if (b != OSPF_TYPE_DD)
                    flt_matching = 1'b0;
            end else if (p == POS_OSPF_LEN) begin
                flt_ospf_len = flt_window[15:0];
            end else if (!flt_lsu) begin
                if (p == POS_DD_LSA_TYPE) begin
                    if (flt_ospf_len == DD_EMPTY_LEN)
                        flt_held = REASON_PASS;
                    else if (b != LSA_ROUTER)
                        flt_held = REASON_DD_NONROUTER;
                    else if (flt_ospf_len != DD_ONE_LSA_LEN)
                        flt_held = REASON_DD_EXTRA;
                    else
                        flt_held = REASON_PASS;
                end else if (p == POS_LINK_COUNT) begin
                    // The DD LSA header ends where an LSU would carry its link count.
                    if (flt_held != REASON_PASS)
                        latch_drop(flt_held);
                    else
                        flt_matching = 1'b0;
                end
            end else begin
                if (p == POS_LSU_COUNT) begin
                    if (flt_window != cfg_lsa_count)
                        latch_drop(REASON_LSA_COUNT);
                end else if (p == POS_LSU_LSA_TYPE) begin
                    flt_held = (b != LSA_ROUTER) ? REASON_LSU_NONROUTER : REASON_PASS;
                end else if (p == POS_LSU_HDR_END) begin
                    if (flt_held != REASON_PASS)
                        latch_drop(flt_held);
                end else if (p == POS_LINK_COUNT) begin
                    if (flt_window[15:0] > cfg_max_links)
                        latch_drop(REASON_LINKS);
                end else if (p >= LINK_FIRST_END) begin
                    off = p - LINK_FIRST_END;
                    if (off % LINK_SIZE == 0 && off / LINK_SIZE < MAX_LINKS_SCANNED) begin
                        if (flt_window[31:24] == LINK_P2P)
                            flt_p2p = 1'b1;
                        else if (flt_window[31:24] == LINK_BROADCAST)
                            latch_drop(REASON_BROADCAST);
                    end
                end
            end
        end
        if (flt_pos != POS_MAX)
            flt_pos = flt_pos + 8'd1;
        if (last) begin
            if (flt_decided)
                why = flt_held;
            else if (p < POS_MIN_FRAME)
                why = REASON_SHORT;
            else if (flt_matching && flt_lsu && p >= LINKS_START - 1 && !flt_p2p)
                why = REASON_NO_P2P;
            expected_verdicts.push_back('{drop: (why != REASON_PASS), reason: why});
            clear_frame_state();
        end
    endtask

    // Frame construction.
    task automatic push_random(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic push_fill(input int n, input logic [7:0] v);
        repeat (n) frame_bytes.push_back(v);
    endtask

    task automatic push_word(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            frame_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic begin_ospf(input logic [7:0] ospf_type, input logic [15:0] ospf_len);
        frame_bytes.delete();
        push_random(OSPF_BODY);
        frame_bytes[POS_ETYPE_OUTER - 1] = ETHERTYPE_IPV4[15:8];
        frame_bytes[POS_ETYPE_OUTER]     = ETHERTYPE_IPV4[7:0];
        frame_bytes[POS_PROTO_GRE]       = PROTO_GRE;
        frame_bytes[POS_ETYPE_INNER - 1] = ETHERTYPE_IPV4[15:8];
        frame_bytes[POS_ETYPE_INNER]     = ETHERTYPE_IPV4[7:0];
        frame_bytes[POS_PROTO_OSPF]      = PROTO_OSPF;
        frame_bytes[POS_OSPF_TYPE]       = ospf_type;
        frame_bytes[POS_OSPF_LEN - 1]    = ospf_len[15:8];
        frame_bytes[POS_OSPF_LEN]        = ospf_len[7:0];
    endtask

    // LS Update with one LSA header and the router LSA body up to its link count.
    task automatic build_lsu(input logic [31:0] lsa_count, input logic [7:0] lsa_type,
                             input logic [15:0] link_count);
        begin_ospf(OSPF_TYPE_LSU, 16'($urandom));
        push_word(lsa_count, 4);
        push_random(3);
        frame_bytes.push_back(lsa_type);
        push_random(16);
        push_random(2);
        push_word({16'h0, link_count}, 2);
    endtask

    task automatic add_link(input logic [7:0] link_type);
        push_random(8);
        frame_bytes.push_back(link_type);
        push_random(3);
    endtask

    task automatic build_dd(input logic [15:0] ospf_len, input logic [7:0] lsa_type);
        begin_ospf(OSPF_TYPE_DD, ospf_len);
        push_random(8);
        push_random(3);
        frame_bytes.push_back(lsa_type);
        push_random(16);
    endtask

    // Sends the first keep bytes of the frame, or all of it when keep is zero.
    task automatic queue_frame(input int keep);
        int n;
        n = (keep <= 0 || keep > frame_bytes.size()) ? frame_bytes.size() : keep;
        for (int i = 0; i < n; i++)
            pending_bytes.push_back('{data: frame_bytes[i], last: (i == n - 1)});
    endtask

    task automatic queue_random_frame();
        int          kind;
        int          lim;
        int          nrec;
        int          r;
        int          keep;
        logic [31:0] cnt;
        logic [7:0]  typ;
        logic [15:0] nl;
        logic [15:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 55 || kind >= 85) begin
            cnt = ($urandom_range(0, 9) == 0) ? 32'($urandom) : cfg_lsa_count;
            typ = ($urandom_range(0, 9) == 0) ? 8'($urandom) : LSA_ROUTER;
            lim = (cfg_max_links > 11) ? 11 : cfg_max_links;
            nl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim));
            build_lsu(cnt, typ, nl);
            nrec = (nl > 12) ? $urandom_range(0, 12) : nl;
            repeat (nrec) begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    add_link(LINK_P2P);
                else if (r == 5)
                    add_link(LINK_BROADCAST);
                else if (r < 8)
                    add_link(8'($urandom_range(3, 4)));
                else
                    add_link(8'($urandom));
            end
            if (kind >= 85) begin
                // Break one of the fields that select the GRE/OSPF path.
                case ($urandom_range(0, 4))
                    0: frame_bytes[POS_ETYPE_OUTER - $urandom_range(0, 1)] = 8'($urandom);
                    1: frame_bytes[POS_PROTO_GRE] = 8'($urandom);
                    2: frame_bytes[POS_ETYPE_INNER - $urandom_range(0, 1)] = 8'($urandom);
                    3: frame_bytes[POS_PROTO_OSPF] = 8'($urandom);
                    default: frame_bytes[POS_OSPF_TYPE] = 8'($urandom);
                endcase
            end
        end else if (kind < 75) begin
            case ($urandom_range(0, 2))
                0: len = DD_EMPTY_LEN;
                1: len = DD_ONE_LSA_LEN;
                default: len = 16'($urandom);
            endcase
            typ = ($urandom_range(0, 4) == 0) ? 8'($urandom) : LSA_ROUTER;
            build_dd(len, typ);
        end else begin
            frame_bytes.delete();
            push_random($urandom_range(1, 80));
        end
        if ($urandom_range(0, 3) == 0)
            push_random($urandom_range(1, 20));
        keep = ($urandom_range(0, 6) == 0) ? $urandom_range(1, frame_bytes.size()) : 0;
        queue_frame(keep);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LSA_COUNT)
            cfg_lsa_count = data;
        else if (addr == ADDR_MAX_LINKS)
            cfg_max_links = data[15:0];
    endtask

    // Returns once every queued byte is taken and every verdict has come back.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Byte driver.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_wait = 0;
        end else begin
            if (in_valid && !in_stall)
                track_byte(frame_byte, end_of_frame);
            if (!in_valid || !in_stall) begin
                if (in_wait > 0) begin
                    in_wait--;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    next_beat = pending_bytes.pop_front();
                    frame_byte   <= next_beat.data;
                    end_of_frame <= next_beat.last;
                    in_valid     <= 1'b1;
                    in_wait = draw_wait(calm_in);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor and output stall.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_wait = 0;
        end else if (out_valid && !out_stall) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected verdict drop=%0b reason=%0d",
                                          drop, reason));
            end else begin
                want = expected_verdicts.pop_front();
                if (drop !== want.drop)
                    report_mismatch($sformatf("drop %0b, expected %0b", drop, want.drop));
                if (reason !== want.reason)
                    report_mismatch($sformatf("reason %0d, expected %0d",
                                              reason, want.reason));
            end
            out_wait = draw_wait(calm_out);
            out_stall <= (out_wait != 0);
        end else if (out_stall) begin
            if (out_wait > 0)
                out_wait--;
            out_stall <= (out_wait != 0);
        end
    end

    // Switches each side between stretches of random idling and stretches of none.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            calm_in <= !calm_in;
        if ($urandom_range(0, 299) == 0)
            calm_out <= !calm_out;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clear_frame_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: frame length limits, every drop reason, truncation.
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        queue_frame(0);
        frame_bytes.delete();
        push_random(13);
        queue_frame(0);
        frame_bytes.delete();
        push_fill(14, 8'hFF);
        queue_frame(0);
        frame_bytes.delete();
        push_fill(14, 8'h00);
        queue_frame(0);
        build_lsu(32'd1, LSA_ROUTER, 16'd2);
        add_link(LINK_P2P);
        add_link(LINK_STUB);
        queue_frame(0);
        build_lsu(32'd2, LSA_ROUTER, 16'd1);
        add_link(LINK_P2P);
        queue_frame(0);
        build_lsu(32'd1, 8'd2, 16'd1);
        add_link(LINK_P2P);
        queue_frame(0);
        build_lsu(32'd1, LSA_ROUTER, 16'd3);
        repeat (3) add_link(LINK_P2P);
        queue_frame(0);
        build_lsu(32'd1, LSA_ROUTER, 16'd2);
        add_link(LINK_P2P);
        add_link(LINK_BROADCAST);
        queue_frame(0);
        build_lsu(32'd1, LSA_ROUTER, 16'd2);
        add_link(LINK_STUB);
        add_link(LINK_STUB);
        queue_frame(0);
        // Cut right after the link count, then one byte before it.
        build_lsu(32'd1, LSA_ROUTER, 16'd1);
        add_link(LINK_P2P);
        queue_frame(LINKS_START);
        build_lsu(32'd1, LSA_ROUTER, 16'd1);
        add_link(LINK_P2P);
        queue_frame(LINKS_START - 1);
        // A pending non-router reason must not leak out of a truncated header.
        build_lsu(32'd1, 8'hFF, 16'd1);
        queue_frame(100);
        build_dd(DD_EMPTY_LEN, 8'h00);
        queue_frame(0);
        build_dd(DD_ONE_LSA_LEN, 8'hFF);
        queue_frame(0);
        build_dd(16'hFFFF, LSA_ROUTER);
        queue_frame(0);
        build_dd(DD_ONE_LSA_LEN, LSA_ROUTER);
        queue_frame(0);
        build_dd(16'd60, 8'd7);
        queue_frame(100);
        begin_ospf(OSPF_TYPE_HELLO, 16'd44);
        push_random(40);
        queue_frame(0);
        build_lsu(32'd1, LSA_ROUTER, 16'd1);
        add_link(LINK_BROADCAST);
        frame_bytes[POS_ETYPE_OUTER] = ETYPE_OTHER_LO;
        queue_frame(0);
        // Frames past the position counter's range.
        build_lsu(32'd1, LSA_ROUTER, 16'd1);
        add_link(LINK_P2P);
        push_fill(200, 8'h00);
        queue_frame(0);
        build_lsu(32'hFFFF_FFFF, LSA_ROUTER, 16'd1);
        push_fill(180, LINK_BROADCAST);
        queue_frame(0);
        repeat (14) queue_random_frame();
        wait_idle();

        apb_write(ADDR_LSA_COUNT, 32'd0);
        apb_write(ADDR_MAX_LINKS, 32'd0);
        // Links beyond a zero link count are still scanned.
        build_lsu(32'd0, LSA_ROUTER, 16'd0);
        add_link(LINK_P2P);
        queue_frame(0);
        build_lsu(32'd0, LSA_ROUTER, 16'd1);
        add_link(LINK_P2P);
        queue_frame(0);
        repeat (8) queue_random_frame();
        wait_idle();

        apb_write(ADDR_LSA_COUNT, 32'hFFFF_FFFF);
        apb_write(ADDR_MAX_LINKS, 32'h0000_FFFF);
        // Only the first ten links count toward the point-to-point check.
        build_lsu(32'hFFFF_FFFF, LSA_ROUTER, 16'hFFFF);
        repeat (MAX_LINKS_SCANNED) add_link(LINK_STUB);
        add_link(LINK_P2P);
        queue_frame(0);
        build_lsu(32'hFFFF_FFFF, LSA_ROUTER, 16'hFFFF);
        repeat (MAX_LINKS_SCANNED - 1) add_link(LINK_STUB);
        add_link(LINK_P2P);
        queue_frame(0);
        build_lsu(32'd0, LSA_ROUTER, 16'd1);
        add_link(LINK_P2P);
        queue_frame(0);
        repeat (8) queue_random_frame();
        wait_idle();

        repeat (2) begin
            apb_write(ADDR_LSA_COUNT,
                      ($urandom_range(0, 1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 3)));
            apb_write(ADDR_MAX_LINKS, {16'($urandom), 16'($urandom_range(0, 12))});
            repeat (12) queue_random_frame();
            wait_idle();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

FILE: gre_ospf_lsa_packet_filter.f
rtl/core/golpf_pkg.sv
rtl/core/golpf_front.sv
rtl/core/golpf_queue.sv
rtl/core/golpf_back.sv
rtl/core/gre_ospf_lsa_packet_filter.sv
rtl/core/golpf_checker.sv
bench/tb.sv
